### rtl/b64enc_pkg.sv
// Shared types, constants and the sextet-to-character mapping for the base64 encoder.
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ch;
    case (v) inside
      [6'd0:6'd25]:  ch = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: ch = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: ch = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         ch = 8'h2B;
      default:       ch = 8'h2F;
    endcase
    return ch;
  endfunction

endpackage

### rtl/b64enc_front.sv
// Front end: gathers input bytes into groups of up to three and pushes complete groups.
module b64enc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 final_byte,
  output logic                 push_valid,
  input  logic                 push_ready,
  output b64enc_pkg::group_t   push_group
);
  import b64enc_pkg::*;

  logic [1:0] pending_count;
  logic [1:0] pending_count_next;
  logic [7:0] byte0;
  logic [7:0] byte0_next;
  logic [7:0] byte1;
  logic [7:0] byte1_next;
  logic       accept;
  logic       completes;
  logic [7:0] g0;
  logic [7:0] g1;
  logic [7:0] g2;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign completes = final_byte || (pending_count >= 2'd2);

  always_comb begin
    g0 = data_byte;
    g1 = 8'h00;
    g2 = 8'h00;
    case (pending_count)
      2'd0: begin
        g0 = data_byte;
      end
      2'd1: begin
        g0 = byte0;
        g1 = data_byte;
      end
      default: begin
        g0 = byte0;
        g1 = byte1;
        g2 = data_byte;
      end
    endcase
  end

  assign push_valid        = accept && completes;
  assign push_group.bits   = {g0, g1, g2};
  assign push_group.nbytes = (pending_count >= 2'd2) ? 2'd3 : pending_count + 2'd1;
  assign push_group.fin    = final_byte;

  always_comb begin
    pending_count_next = pending_count;
    byte0_next         = byte0;
    byte1_next         = byte1;
    if (accept) begin
      if (completes) begin
        pending_count_next = 2'd0;
        byte0_next         = 8'h00;
        byte1_next         = 8'h00;
      end else begin
        pending_count_next = pending_count + 2'd1;
        if (pending_count == 2'd0) begin
          byte0_next = data_byte;
        end else begin
          byte1_next = data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      byte0         <= 8'h00;
      byte1         <= 8'h00;
    end else begin
      pending_count <= pending_count_next;
      byte0         <= byte0_next;
      byte1         <= byte1_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pending_count <= 2'd2)
    else $error("pending count beyond two");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    push_valid |=> pending_count == 2'd0)
    else $error("pending bytes kept after group push");

endmodule

### rtl/b64enc_queue.sv
// Short group queue between the front end and the character emitter.
module b64enc_queue #(
  parameter int unsigned DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  b64enc_pkg::group_t   push_group,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output b64enc_pkg::group_t   pop_group
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  group_t          slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign pop_group  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt)
    else $error("queue count overflow");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("push not counted");

endmodule

### rtl/b64enc_back.sv
// Back end: emits the four characters of each queued group through an output register.
module b64enc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  b64enc_pkg::group_t   pop_group,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 end_of_text
);
  import b64enc_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic [5:0] sextet;
  logic [7:0] ch;
  logic       last;

  assign load      = pop_valid && (!out_valid || out_ready);
  assign pop_ready = load && (idx == 2'd3);

  always_comb begin
    case (idx)
      2'd0:    sextet = pop_group.bits[23:18];
      2'd1:    sextet = pop_group.bits[17:12];
      2'd2:    sextet = pop_group.bits[11:6];
      default: sextet = pop_group.bits[5:0];
    endcase
    ch   = (idx <= pop_group.nbytes) ? sextet_char(sextet) : PadChar;
    last = pop_group.fin && (idx == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= ch;
      end_of_text <= last;
    end
  end

  a_wrap_after_group: assert property (@(posedge clk) disable iff (rst)
    pop_ready |=> idx == 2'd0)
    else $error("character index not wrapped after group");

  a_eot_on_fourth: assert property (@(posedge clk) disable iff (rst)
    (load && last) |-> pop_ready)
    else $error("end of text not on last character of group");

endmodule

### rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder.
// Input channel: one raw byte per transaction (data_byte), final_byte set on the
// last byte of a text. Output channel: one ASCII character per transaction
// (out_char), end_of_text set on the last character of the encoded text.
// Every third byte, or any byte with final_byte set, closes a group; the group
// enters a short queue and leaves as four characters, '=' padding a short group.
// The byte that closes a group writes it into the queue; the emitter then loads
// its first character into the output register, and the rest follow one per
// cycle while the receiver is ready. Bytes are accepted every cycle while the
// queue has room.
// Reset clears pending bytes, empties the queue and drops out_valid; the next byte starts
// a new text. When the receiver stalls, the output register holds its
// character, the queue fills, and in_ready falls once the queue is full.
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       end_of_text
);
  import b64enc_pkg::*;

  logic   push_valid;
  logic   push_ready;
  group_t push_group;
  logic   pop_valid;
  logic   pop_ready;
  group_t pop_group;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_group (push_group)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_group (push_group),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_group  (pop_group)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_group   (pop_group),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .end_of_text (end_of_text)
  );

endmodule

### tb/b64_char_checker.sv
// Watches both channels of the base64 encoder, predicts each character and compares.
module b64_char_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       end_of_text,
  output int         fail_count,
  output int         waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } b64_char_t;

  localparam logic [0:63][7:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64_char_t  char_q[$];
  b64_char_t  want;
  logic [7:0] held_bytes[2] = '{8'h00, 8'h00};
  logic [1:0] held_cnt = 2'd0;

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] grp[3];
    logic [5:0] sx[4];
    logic [1:0] cnt;
    int         nbytes;
    b64_char_t  c;
    cnt = (held_cnt > 2'd2) ? 2'd2 : held_cnt;
    if (cnt < 2'd2 && !fin) begin
      held_bytes[cnt[0]] = b;
      held_cnt = cnt + 2'd1;
    end else begin
      grp[0] = (cnt >= 2'd1) ? held_bytes[0] : 8'h00;
      grp[1] = (cnt >= 2'd2) ? held_bytes[1] : 8'h00;
      grp[2] = 8'h00;
      grp[cnt] = b;
      nbytes = int'(cnt) + 1;
      sx[0] = grp[0][7:2];
      sx[1] = {grp[0][1:0], grp[1][7:4]};
      sx[2] = {grp[1][3:0], grp[2][7:6]};
      sx[3] = grp[2][5:0];
      for (int k = 0; k < 4; k++) begin
        c.ch  = (k <= nbytes) ? B64Alphabet[sx[k]] : b64enc_pkg::PadChar;
        c.eot = fin && (k == 3);
        char_q.push_back(c);
      end
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_cnt = 2'd0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          $error("out_char: no character expected, actual %h", out_char);
          fail_count++;
        end else begin
          want = char_q.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_char);
            fail_count++;
          end
          if (end_of_text !== want.eot) begin
            $error("end_of_text: expected %b, actual %b", want.eot, end_of_text);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) encode_byte(data_byte, final_byte);
    end
    waiting = char_q.size();
  end

endmodule

### tb/tb.sv
// Testbench top: drives bytes into the base64 encoder, stalls the receiver and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] out_char;
  logic       end_of_text;
  logic       calm = 1'b0;
  int         fail_count;
  int         waiting;
  int         hold_left = 0;
  int         bytes_sent = 0;

  localparam int NumDirected = 20;
  localparam logic [7:0] DirBytes[NumDirected] = '{
    8'h00, 8'hFF, 8'h4D, 8'h61, 8'h4D, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'hFB, 8'hEF, 8'hBE, 8'h80, 8'h01, 8'h7F
  };
  localparam logic DirFinal[NumDirected] = '{
    1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1
  };

  base64_stream_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .end_of_text (end_of_text)
  );

  b64_char_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .end_of_text (end_of_text),
    .fail_count  (fail_count),
    .waiting     (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      hold_left = $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
      hold_left = $urandom_range(0, 39);
    end
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      final_byte <= 1'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain_chars();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
  endtask

  initial begin
    int len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    final_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++) send_byte(DirBytes[i], DirFinal[i]);
    drain_chars();

    while (bytes_sent < NumDirected + 80) begin
      if (bytes_sent >= NumDirected + 65) calm <= 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int j = 0; j < len; j++) send_byte(pick_byte(), j == len - 1);
      if (bytes_sent >= NumDirected + 40 && bytes_sent < NumDirected + 48) drain_chars();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

endmodule

### sim.f
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
tb/b64_char_checker.sv
tb/tb.sv
